>>> hw/rtl/resp_request_parser_top_assert.svh
// ----------------------------------------------------------------------------
// RESP request parser assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_PARSER_TOP_ASSERT_SVH
`define RESP_REQUEST_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define RPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define RPP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RPP_ASSERT(lbl, prop, msg)
`define RPP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/rpp_pkg.sv
// ----------------------------------------------------------------------------
// RESP request parser package
// Result record, status and error codes, output queue sizing.
// ----------------------------------------------------------------------------
package rpp_pkg;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_INVALID    = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_EMPTY      = 4'd1;
    localparam logic [3:0] ERR_NO_ARRAY   = 4'd2;
    localparam logic [3:0] ERR_BAD_COUNT  = 4'd3;
    localparam logic [3:0] ERR_CRLF       = 4'd4;
    localparam logic [3:0] ERR_NO_BULK    = 4'd5;
    localparam logic [3:0] ERR_BAD_LENGTH = 4'd6;
    localparam logic [3:0] ERR_DATA_SHORT = 4'd7;
    localparam logic [3:0] ERR_BAD_DB     = 4'd8;

    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] element_number;
        logic        element_done;
        logic [1:0]  parse_status;
        logic [3:0]  error_code;
        logic [31:0] db_index;
        logic        is_final;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_emit;

endpackage

>>> hw/rtl/rpp_parser.sv
// ----------------------------------------------------------------------------
// RESP request parser core
// Per-byte state update; yields up to two result records per beat.
// ----------------------------------------------------------------------------
module rpp_parser import rpp_pkg::*; #(
    parameter int COUNT_BITS  = 16,
    parameter int LENGTH_BITS = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_has_byte,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output t_emit      o_emit0,
    output t_emit      o_emit1
);

    localparam int CW = COUNT_BITS + 1;
    localparam int LW = LENGTH_BITS + 1;
    localparam int DW = 33;

    localparam logic [CW-1:0] CMAX = {1'b1, {COUNT_BITS{1'b0}}};
    localparam logic [LW-1:0] LMAX = {1'b1, {LENGTH_BITS{1'b0}}};
    localparam logic [DW-1:0] DLIM = {2'b01, 31'd1};
    localparam logic [DW-1:0] MAG_NEG = {2'b01, 31'd0};
    localparam logic [DW-1:0] MAG_POS = {2'b00, {31{1'b1}}};

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [3:0] {
        PH_STAR, PH_COUNT, PH_COUNT_LF, PH_DOLLAR, PH_LEN, PH_LEN_LF,
        PH_DATA, PH_DATA_CR, PH_DATA_LF
    } t_phase;

    typedef enum logic [2:0] {
        DB_WS, DB_SIGN, DB_DIGITS, DB_STOP_EMPTY, DB_STOP_DIGITS, DB_DONE
    } t_dbph;

    t_phase                 r_phase, n_phase;
    logic [CW-1:0]          r_count, n_count;
    logic [COUNT_BITS-1:0]  r_elem_left, n_elem_left;
    logic [COUNT_BITS-1:0]  r_cur_elem, n_cur_elem;
    logic [LW-1:0]          r_bytes_left, n_bytes_left;
    logic [DW-1:0]          r_db, n_db;
    t_dbph                  r_dbph, n_dbph;
    logic                   r_db_neg, n_db_neg;
    logic                   r_digit_seen, n_digit_seen;
    logic                   r_finished, n_finished;

    // saturating decimal accumulate: acc*10 + d, capped at lim
    function automatic logic [DW-1:0] acc_digit(input logic [DW-1:0] acc,
                                                input logic [7:0] b,
                                                input logic [DW-1:0] lim);
        logic [DW+3:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (DW+4)'(b - CH_ZERO);
        acc_digit = (v > {4'b0, lim}) ? lim : v[DW-1:0];
    endfunction

    function automatic t_result mk_status(input logic [1:0] st, input logic [3:0] code,
                                          input logic [31:0] db);
        t_result r;
        r = '0;
        r.result_kind  = 1'b1;
        r.parse_status = st;
        r.error_code   = code;
        r.db_index     = db;
        r.is_final     = 1'b1;
        mk_status = r;
    endfunction

    logic        b_digit;
    logic        b_ws;
    logic        st_v;
    logic [1:0]  st_code;
    logic [3:0]  st_err;
    logic        pay_v;
    t_result     pay;
    logic        end_v;
    logic [3:0]  end_err;
    logic [31:0] db_out;
    logic [DW-1:0] db_mag;

    always_comb begin
        b_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
        b_ws    = (i_data_byte == CH_SPACE) ||
                  ((i_data_byte >= CH_TAB) && (i_data_byte <= CH_CR));
        n_phase      = r_phase;
        n_count      = r_count;
        n_elem_left  = r_elem_left;
        n_cur_elem   = r_cur_elem;
        n_bytes_left = r_bytes_left;
        n_db         = r_db;
        n_dbph       = r_dbph;
        n_db_neg     = r_db_neg;
        n_digit_seen = r_digit_seen;
        n_finished   = r_finished;
        st_v    = 1'b0;
        st_code = ST_OK;
        st_err  = ERR_NONE;
        pay_v   = 1'b0;
        pay     = '0;
        end_v   = 1'b0;
        end_err = ERR_NONE;
        db_mag  = r_db_neg ? MAG_NEG : MAG_POS;

        if (i_accept) begin
            if (!i_has_byte || r_finished) begin
                if (i_end_of_buffer && !r_finished) begin
                    end_v = 1'b1;
                    end_err = (r_phase == PH_STAR) ? ERR_EMPTY :
                              ((r_phase == PH_DATA) ? ERR_DATA_SHORT : ERR_NONE);
                end
            end else begin
                unique case (r_phase)
                    PH_STAR: begin
                        if (i_data_byte == CH_STAR) begin
                            n_phase = PH_COUNT;
                            n_count = '0;
                            n_digit_seen = 1'b0;
                        end else begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_NO_ARRAY;
                        end
                    end
                    PH_COUNT: begin
                        if (i_data_byte == CH_CR) begin
                            n_phase = PH_COUNT_LF;
                        end else if (b_digit) begin
                            n_count = CW'(acc_digit(DW'(r_count), i_data_byte, DW'(CMAX)));
                            n_digit_seen = 1'b1;
                        end else begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_BAD_COUNT;
                        end
                    end
                    PH_COUNT_LF: begin
                        if (i_data_byte != CH_LF) begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_CRLF;
                        end else if (!r_digit_seen || r_count >= CMAX) begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_BAD_COUNT;
                        end else begin
                            n_elem_left = r_count[COUNT_BITS-1:0];
                            n_cur_elem  = '0;
                            if (r_count == '0) begin
                                st_v = 1'b1;
                            end else begin
                                n_phase = PH_DOLLAR;
                            end
                        end
                    end
                    PH_DOLLAR: begin
                        if (i_data_byte == CH_DOLLAR) begin
                            n_phase = PH_LEN;
                            n_bytes_left = '0;
                            n_digit_seen = 1'b0;
                        end else begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_NO_BULK;
                        end
                    end
                    PH_LEN: begin
                        if (i_data_byte == CH_CR) begin
                            n_phase = PH_LEN_LF;
                        end else if (b_digit) begin
                            n_bytes_left = LW'(acc_digit(DW'(r_bytes_left), i_data_byte,
                                                         DW'(LMAX)));
                            n_digit_seen = 1'b1;
                        end else begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_BAD_LENGTH;
                        end
                    end
                    PH_LEN_LF: begin
                        if (i_data_byte != CH_LF) begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_CRLF;
                        end else if (!r_digit_seen || r_bytes_left >= LMAX) begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_BAD_LENGTH;
                        end else begin
                            n_phase = (r_bytes_left == '0) ? PH_DATA_CR : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (r_cur_elem == '0) begin
                            unique case (r_dbph)
                                DB_WS: begin
                                    if (b_ws) begin
                                        n_dbph = DB_WS;
                                    end else if (i_data_byte == CH_PLUS ||
                                                 i_data_byte == CH_MINUS) begin
                                        n_db_neg = (i_data_byte == CH_MINUS);
                                        n_dbph = DB_SIGN;
                                    end else if (b_digit) begin
                                        n_db = acc_digit(r_db, i_data_byte, DLIM);
                                        n_dbph = DB_DIGITS;
                                    end else begin
                                        n_dbph = DB_STOP_EMPTY;
                                    end
                                end
                                DB_SIGN: begin
                                    if (b_digit) begin
                                        n_db = acc_digit(r_db, i_data_byte, DLIM);
                                        n_dbph = DB_DIGITS;
                                    end else begin
                                        n_dbph = DB_STOP_EMPTY;
                                    end
                                end
                                DB_DIGITS: begin
                                    if (b_digit) begin
                                        n_db = acc_digit(r_db, i_data_byte, DLIM);
                                    end else begin
                                        n_dbph = DB_STOP_DIGITS;
                                    end
                                end
                                default: begin
                                    n_dbph = r_dbph;
                                end
                            endcase
                        end else begin
                            pay_v = 1'b1;
                            pay.payload_byte   = i_data_byte;
                            pay.element_number = 16'(r_cur_elem);
                            pay.element_done   = (r_bytes_left == LW'(1));
                        end
                        n_bytes_left = r_bytes_left - LW'(1);
                        if (r_bytes_left == LW'(1)) begin
                            n_phase = PH_DATA_CR;
                        end
                    end
                    PH_DATA_CR: begin
                        if (!i_end_of_buffer) begin
                            if (i_data_byte == CH_CR) begin
                                n_phase = PH_DATA_LF;
                            end else begin
                                st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_CRLF;
                            end
                        end
                    end
                    PH_DATA_LF: begin
                        if (i_data_byte != CH_LF) begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_CRLF;
                        end else if (r_cur_elem == '0 &&
                                     !((r_dbph == DB_DIGITS || r_dbph == DB_STOP_DIGITS) &&
                                       r_db <= db_mag)) begin
                            st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_BAD_DB;
                        end else begin
                            if (r_cur_elem == '0) begin
                                n_db = r_db_neg ? (DW'(0) - r_db) : r_db;
                                n_dbph = DB_DONE;
                            end
                            n_cur_elem  = r_cur_elem + COUNT_BITS'(1);
                            n_elem_left = r_elem_left - COUNT_BITS'(1);
                            if (r_elem_left == COUNT_BITS'(1)) begin
                                st_v = 1'b1;
                            end else begin
                                n_phase = PH_DOLLAR;
                            end
                        end
                    end
                    default: begin
                        st_v = 1'b1; st_code = ST_INVALID; st_err = ERR_NO_ARRAY;
                    end
                endcase
                if (st_v) begin
                    n_finished = 1'b1;
                end
                if (i_end_of_buffer && !n_finished) begin
                    end_v = 1'b1;
                    end_err = (n_phase == PH_DATA) ? ERR_DATA_SHORT : ERR_NONE;
                end
            end
        end

        db_out = (n_dbph == DB_DONE) ? n_db[31:0] : 32'd0;

        o_emit0 = '0;
        o_emit1 = '0;
        if (pay_v) begin
            o_emit0.valid = 1'b1;
            o_emit0.res   = pay;
        end else if (st_v) begin
            o_emit0.valid = 1'b1;
            o_emit0.res   = mk_status(st_code, st_err, db_out);
        end
        if (end_v) begin
            if (pay_v || st_v) begin
                o_emit1.valid = 1'b1;
                o_emit1.res   = mk_status(ST_INCOMPLETE, end_err, db_out);
            end else begin
                o_emit0.valid = 1'b1;
                o_emit0.res   = mk_status(ST_INCOMPLETE, end_err, db_out);
            end
        end

        // end mark starts a fresh request
        if (i_accept && i_end_of_buffer) begin
            n_phase      = PH_STAR;
            n_count      = '0;
            n_elem_left  = '0;
            n_cur_elem   = '0;
            n_bytes_left = '0;
            n_db         = '0;
            n_dbph       = DB_WS;
            n_db_neg     = 1'b0;
            n_digit_seen = 1'b0;
            n_finished   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_STAR;
            r_count      <= '0;
            r_elem_left  <= '0;
            r_cur_elem   <= '0;
            r_bytes_left <= '0;
            r_db         <= '0;
            r_dbph       <= DB_WS;
            r_db_neg     <= 1'b0;
            r_digit_seen <= 1'b0;
            r_finished   <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_elem_left  <= n_elem_left;
            r_cur_elem   <= n_cur_elem;
            r_bytes_left <= n_bytes_left;
            r_db         <= n_db;
            r_dbph       <= n_dbph;
            r_db_neg     <= n_db_neg;
            r_digit_seen <= n_digit_seen;
            r_finished   <= n_finished;
        end
    end

endmodule

>>> hw/rtl/rpp_out_queue.sv
// ----------------------------------------------------------------------------
// RESP request parser result queue
// Three-entry result register queue; takes up to two results per beat.
// ----------------------------------------------------------------------------
module rpp_out_queue import rpp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_emit   i_push0,
    input  t_emit   i_push1,
    output logic    o_can_accept,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    t_result            r_ent [QUEUE_DEPTH];
    t_result            n_ent [QUEUE_DEPTH];
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic [QCNT_W-1:0]  cnt_p;
    logic [QCNT_W-1:0]  idx1;
    logic               pop;

    assign o_valid      = (r_cnt != '0);
    assign o_res        = r_ent[0];
    // room for two results regardless of the downstream side
    assign o_can_accept = (r_cnt < QCNT_W'(QUEUE_DEPTH - 1));
    assign pop          = o_valid && i_ready;

    always_comb begin
        cnt_p = r_cnt - QCNT_W'(pop);
        idx1  = cnt_p + QCNT_W'(i_push0.valid);
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (pop && k < QUEUE_DEPTH - 1) begin
                n_ent[k] = r_ent[k+1];
            end else begin
                n_ent[k] = r_ent[k];
            end
            if (i_push0.valid && cnt_p == QCNT_W'(k)) begin
                n_ent[k] = i_push0.res;
            end
            if (i_push1.valid && idx1 == QCNT_W'(k)) begin
                n_ent[k] = i_push1.res;
            end
        end
        n_cnt = idx1 + QCNT_W'(i_push1.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            r_ent[k] <= n_ent[k];
        end
    end

endmodule

>>> hw/rtl/resp_request_parser_top.sv
// ----------------------------------------------------------------------------
// RESP request parser top
// Parses an array-of-bulk-strings request byte stream into payload beats and
// one final status beat per request.
// ----------------------------------------------------------------------------
// One request byte is taken per cycle while the result queue has room; its
// state update finishes in that cycle. Most bytes give zero or one result
// beat; a byte that carries the end mark while element data is still arriving
// gives two (its payload byte and the incomplete status). The three-entry
// result queue sets the rate: input is taken while it holds at most one beat,
// so even with the output side always ready a two-result byte stalls input.
module resp_request_parser_top import rpp_pkg::*; #(
    parameter int COUNT_BITS  = 16,
    parameter int LENGTH_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [23:8] element_number, [24] element_done,
    // [26:25] parse_status, [30:27] error_code, [62:31] db_index, [63] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast    // is_final
);

`include "resp_request_parser_top_assert.svh"

    logic    w_accept;
    t_emit   w_emit0;
    t_emit   w_emit1;
    t_result w_res;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    rpp_parser #(
        .COUNT_BITS  (COUNT_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_has_byte      (s_axis_tuser),
        .i_data_byte     (s_axis_tdata),
        .i_end_of_buffer (s_axis_tlast),
        .o_emit0         (w_emit0),
        .o_emit1         (w_emit1)
    );

    rpp_out_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push0      (w_emit0),
        .i_push1      (w_emit1),
        .o_can_accept (s_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_res        (w_res),
        .i_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, w_res.db_index, w_res.error_code, w_res.parse_status,
                           w_res.element_done, w_res.element_number, w_res.payload_byte};
    assign m_axis_tuser = w_res.result_kind;
    assign m_axis_tlast = w_res.is_final;

    `RPP_ASSERT(a_second_is_final, w_emit1.valid |-> (w_emit0.valid && w_emit1.res.is_final), "second result must follow a first one and be a final status")
    `RPP_ASSERT(a_emit_needs_accept, (w_emit0.valid || w_emit1.valid) |-> w_accept, "result produced without an accepted beat")
    `RPP_ASSERT(a_final_is_status, (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser, "final beat is not a status beat")
    `RPP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule
